FILE: design/ifc_pkg.sv
package ifc_pkg;
	localparam logic [7:0] ClampExp = 8'h9D;
	localparam logic [7:0] ExpBias = 8'd127;
	localparam logic [31:0] WordMin = 32'h8000_0000;
	localparam logic [31:0] WordMax = 32'h7FFF_FFFF;
	localparam logic OpWordToSingle = 1'b0;
	localparam logic OpSingleToWord = 1'b1;
endpackage

FILE: design/int_float_conversion_clamped.sv
// int_float_conversion_clamped: word <-> single conversion
// input channel: in_valid/in_ready carry op and operand; op 0 converts a
// signed word to a single (round to nearest even), op 1 converts a single
// to a signed word (truncate toward zero, clamp large values, inf and nan).
// output channel: out_valid/out_ready carry result and fpu_unusable.
// config: cfg_we/cfg_wdata write fpu_usable; when it is 0 each item yields
// result 0 with fpu_unusable set. write it only while the block is idle.
// datapath: operands are registered at transfer (stage 1), the conversion
// is done by one pass of combinational logic into the result register.
// throughput: one item per cycle while out_ready is high; stage 1 and the
// result register form a two-entry pipeline that moves whenever the
// result register frees up.
// stall: when out_ready is low the result register holds and stage 1
// fills, after which in_ready drops; nothing is lost or repeated.
// reset: arst_n clears both valid bits and sets fpu_usable to 1.
module int_float_conversion_clamped
	import ifc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [31:0] operand,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result,
	output logic        fpu_unusable,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);
	logic        fpu_usable_q;
	logic        vld_s1;
	logic        op_s1;
	logic [31:0] opnd_s1;
	logic        vld_s2;
	logic        adv_s2;
	logic [31:0] res_c;

	// word to single
	logic        w_sign;
	logic [31:0] w_mag;
	logic [4:0]  w_p;
	logic [31:0] w_norm;
	logic        w_g, w_st, w_up;
	logic [24:0] w_m;
	logic [7:0]  w_e;
	logic [31:0] w2s;
	// single to word
	logic [7:0]  f_e;
	logic [7:0]  f_sh;
	logic [62:0] f_wide;
	logic [31:0] f_mag;
	logic [31:0] s2w;

	assign adv_s2   = !vld_s2 || out_ready;
	assign in_ready = !vld_s1 || adv_s2;

	always_comb begin
		w_sign = opnd_s1[31];
		w_mag  = w_sign ? (32'd0 - opnd_s1) : opnd_s1;
		w_p    = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (w_mag[i]) w_p = 5'(i);
		end
		w_norm = w_mag << (5'd31 - w_p);
		// mantissa in [31:8], guard bit 7, sticky below
		w_g  = w_norm[7];
		w_st = |w_norm[6:0];
		w_up = w_g && (w_st || w_norm[8]);
		w_m  = {1'b0, w_norm[31:8]} + {24'd0, w_up};
		w_e  = 8'(w_p) + ExpBias + {7'd0, w_m[24]};
		if (w_mag == 32'd0) begin
			w2s = 32'd0;
		end else begin
			w2s = {w_sign, w_e, w_m[24] ? w_m[23:1] : w_m[22:0]};
		end
	end

	always_comb begin
		f_e    = opnd_s1[30:23];
		f_sh   = f_e - ExpBias;
		f_wide = {31'd0, 1'b1, opnd_s1[22:0], 8'd0} << f_sh[4:0];
		f_mag  = f_wide[62:31];
		if (f_e > ClampExp) begin
			s2w = opnd_s1[31] ? WordMin : WordMax;
		end else if (f_e < ExpBias) begin
			s2w = 32'd0;
		end else begin
			s2w = opnd_s1[31] ? (32'd0 - f_mag) : f_mag;
		end
	end

	assign res_c = (op_s1 == OpSingleToWord) ? s2w : w2s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fpu_usable_q <= 1'b1;
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
		end else begin
			if (cfg_we) fpu_usable_q <= cfg_wdata;
			if (in_ready) vld_s1 <= in_valid;
			if (adv_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= op;
			opnd_s1 <= operand;
		end
		if (adv_s2 && vld_s1) begin
			result       <= fpu_usable_q ? res_c : 32'd0;
			fpu_unusable <= !fpu_usable_q;
		end
	end

	assign out_valid = vld_s2;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result))
		else $error("result changed during stall");
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && vld_s2 && !out_ready |-> !in_ready)
		else $error("accepted input with pipeline full");
	a_unusable_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fpu_unusable |-> result == 32'd0)
		else $error("unusable result not zero");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv_s2 |=> out_valid)
		else $error("stage 1 item lost");
endmodule
